// ----- rtl/first_fit_block_allocator_defines.svh -----
// Assertion helpers for the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FFBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FFBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

  // Heap geometry
  localparam int unsigned HEAP_BYTES = 4096;
  localparam int unsigned META_BYTES = 4;
  localparam int unsigned MAX_BLOCKS = 64;

  // Field widths
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 16;

  // Derived widths
  localparam int unsigned IDX_W    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned TOP_W    = $clog2(HEAP_BYTES);
  localparam int unsigned NEWTOP_W = $clog2(HEAP_BYTES + META_BYTES + (1 << SIZE_W));
  localparam int unsigned PAY_W    = (TOP_W + 1 > ADDR_W) ? TOP_W + 1 : ADDR_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_e;

  // One block table entry
  typedef struct packed {
    logic [TOP_W-1:0]  start;
    logic [SIZE_W-1:0] length;
    logic              is_free;
  } entry_t;

  // Table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  // Payload address of a block: start plus header, low address bits
  function automatic logic [ADDR_W-1:0] payload_of(input logic [TOP_W-1:0] start);
    logic [PAY_W-1:0] sum;
    sum = PAY_W'(start) + PAY_W'(META_BYTES);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/ffba_table.sv -----
`timescale 1ns / 1ps

// Block table storage: one write port, one registered read port.
module ffba_table (
  input  logic                      clk_i,
  input  ffba_pkg::wr_req_t         wr_i,
  input  logic [ffba_pkg::IDX_W-1:0] rd_addr_i,
  output ffba_pkg::entry_t          rd_data_o
);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/ffba_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer with one shared magnitude compare: first-fit scan, then carve.
module ffba_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [ffba_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [ffba_pkg::OUT_W-1:0] m_axis_tdata_o,
  output ffba_pkg::wr_req_t          wr_o,
  output logic [ffba_pkg::IDX_W-1:0] rd_addr_o,
  input  ffba_pkg::entry_t           rd_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CARVE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Item under work
  logic                          action_q, action_d;
  logic [ffba_pkg::SIZE_W-1:0]   want_q, want_d;
  logic [ffba_pkg::ADDR_W-1:0]   addr_q, addr_d;

  // Scan pointers: idx reads one ahead of chk
  logic [ffba_pkg::CNT_W-1:0]    idx_q, idx_d;
  logic [ffba_pkg::CNT_W-1:0]    chk_q, chk_d;

  // Allocator state
  logic [ffba_pkg::CNT_W-1:0]    count_q, count_d;
  logic [ffba_pkg::TOP_W-1:0]    top_q, top_d;

  // Pending result and output register
  logic [ffba_pkg::ADDR_W-1:0]   grant_q, grant_d;
  ffba_pkg::status_e             status_q, status_d;
  logic                          out_valid_q, out_valid_d;
  logic [ffba_pkg::OUT_W-1:0]    out_data_q, out_data_d;

  // Shared compare unit
  logic [ffba_pkg::NEWTOP_W-1:0] new_top;
  logic [ffba_pkg::NEWTOP_W-1:0] cmp_a, cmp_b;
  logic                          cmp_ge;
  logic                          addr_match;
  logic                          hit;

  assign new_top = ffba_pkg::NEWTOP_W'(top_q) + ffba_pkg::NEWTOP_W'(ffba_pkg::META_BYTES)
                 + ffba_pkg::NEWTOP_W'(want_q);

  // Scan compares length against request; carve compares new top against heap end
  always_comb begin
    if (state_q == S_CARVE) begin
      cmp_a = new_top;
      cmp_b = ffba_pkg::NEWTOP_W'(ffba_pkg::HEAP_BYTES);
    end else begin
      cmp_a = ffba_pkg::NEWTOP_W'(rd_data_i.length);
      cmp_b = ffba_pkg::NEWTOP_W'(want_q);
    end
  end

  assign cmp_ge     = (cmp_a >= cmp_b);
  assign addr_match = (ffba_pkg::payload_of(rd_data_i.start) == addr_q);
  assign hit        = action_q ? addr_match : (rd_data_i.is_free && cmp_ge);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign rd_addr_o       = idx_q[ffba_pkg::IDX_W-1:0];
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    want_d      = want_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    count_d     = count_q;
    top_d       = top_q;
    grant_d     = grant_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    wr_o        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          action_d = s_axis_tuser_i;
          want_d   = s_axis_tdata_i[ffba_pkg::SIZE_W-1:0];
          addr_d   = s_axis_tdata_i[ffba_pkg::SIZE_W +: ffba_pkg::ADDR_W];
          idx_d    = '0;
          chk_d    = '0;
          grant_d  = '0;
          status_d = ffba_pkg::ST_OK;
          if (!s_axis_tuser_i && (s_axis_tdata_i[ffba_pkg::SIZE_W-1:0] == '0)) begin
            status_d = ffba_pkg::ST_ZERO;
            state_d  = S_DONE;
          end else if (s_axis_tuser_i
                       && (s_axis_tdata_i[ffba_pkg::SIZE_W +: ffba_pkg::ADDR_W] == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        idx_d   = idx_q + 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (chk_q == count_q) begin
          // End of table: free misses, allocate tries a carve
          if (action_q) begin
            status_d = ffba_pkg::ST_UNKNOWN;
            state_d  = S_DONE;
          end else begin
            state_d = S_CARVE;
          end
        end else if (hit) begin
          wr_o.en           = 1'b1;
          wr_o.addr         = chk_q[ffba_pkg::IDX_W-1:0];
          wr_o.data         = rd_data_i;
          wr_o.data.is_free = action_q;
          if (!action_q) begin
            grant_d = ffba_pkg::payload_of(rd_data_i.start);
          end
          state_d = S_DONE;
        end else begin
          chk_d = chk_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_CARVE: begin
        if (cmp_ge) begin
          status_d = ffba_pkg::ST_EXHAUSTED;
        end else if (count_q == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) begin
          status_d = ffba_pkg::ST_TABLE_FULL;
        end else begin
          wr_o.en           = 1'b1;
          wr_o.addr         = count_q[ffba_pkg::IDX_W-1:0];
          wr_o.data.start   = top_q;
          wr_o.data.length  = want_q;
          wr_o.data.is_free = 1'b0;
          grant_d           = ffba_pkg::payload_of(top_q);
          count_d           = count_q + 1'b1;
          top_d             = new_top[ffba_pkg::TOP_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, status_q, grant_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    want_q     <= want_d;
    addr_q     <= addr_d;
    idx_q      <= idx_d;
    chk_q      <= chk_d;
    grant_q    <= grant_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// A zero-size allocate or a null free goes from acceptance to the result word without a table read;
// other items scan the table in order and stop at the first match, and an allocate that misses then carves.
// One item at a time, accepted only while idle; the scan reads one table entry per cycle.
// The result register lets the next item be accepted while a word waits downstream.
// Reset (rst_ni low, async): block count and heap top cleared, output empty; table not cleared.
module first_fit_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [ffba_pkg::IN_W-1:0]  s_axis_tdata_i,  // alloc_bytes[11:0], payload_address[23:12]
  input  logic                       s_axis_tuser_i,  // action: 0 allocate, 1 free
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [ffba_pkg::OUT_W-1:0] m_axis_tdata_o   // granted_address[11:0], status[14:12]
);

  ffba_pkg::wr_req_t          wr;
  logic [ffba_pkg::IDX_W-1:0] rd_addr;
  ffba_pkg::entry_t           rd_data;

  // Sequencer and compare unit
  ffba_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .wr_o            (wr),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data)
  );

  // Block table
  ffba_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// ----- rtl/ffba_checker.sv -----
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"

// Port-level checks on the allocator.
module ffba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [ffba_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                       s_axis_tuser_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [ffba_pkg::OUT_W-1:0] m_axis_tdata_o
);

  // A stalled result word holds
  `FFBA_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result word changed while stalled")

  // Any failure status grants nothing
  `FFBA_ASSERT_IMP(a_fail_no_grant, m_axis_tvalid_o && (m_axis_tdata_o[14:12] != ffba_pkg::ST_OK), m_axis_tdata_o[11:0] == '0, "grant given with failure status")

  // One item at a time: busy right after acceptance
  `FFBA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready stayed high after accept")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ----- bench/first_fit_block_allocator_checker.sv -----
`timescale 1ns / 1ps

// Action codes carried on s_axis tuser, shared by the checker and the bench top
package ffba_tb_pkg;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

endpackage

// Watches both streams, keeps a shadow of the block table and checks every
// output word against the oldest outstanding prediction.
module first_fit_block_allocator_checker
  import ffba_pkg::*;
  import ffba_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [IN_W-1:0]   s_axis_tdata_i,   // alloc_bytes[11:0], payload_address[23:12]
  input  logic              s_axis_tuser_i,   // action
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [OUT_W-1:0]  m_axis_tdata_i,   // granted_address[11:0], status[14:12]
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] grant;
    status_e           status;
  } heap_reply_t;

  // Shadow block table and bump pointer
  logic [TOP_W-1:0]  shadow_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] shadow_len   [MAX_BLOCKS];
  logic              shadow_avail [MAX_BLOCKS];
  int unsigned       blocks_used = 0;
  int unsigned       top_of_heap = 0;

  heap_reply_t replies_due[$];
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Next reply of the allocator for one request, updating the shadow table
  function automatic heap_reply_t predict_reply(input action_e act,
                                                input logic [SIZE_W-1:0] want,
                                                input logic [ADDR_W-1:0] addr);
    heap_reply_t r;
    int unsigned new_top;
    bit          done;
    r.grant  = '0;
    r.status = ST_OK;
    done     = 1'b0;
    if (act == ACT_ALLOC) begin
      if (want == '0) begin
        r.status = ST_ZERO;
      end else begin
        // first fit over existing blocks, no split
        for (int i = 0; i < blocks_used && !done; i++) begin
          if (shadow_avail[i] && shadow_len[i] >= want) begin
            shadow_avail[i] = 1'b0;
            r.grant = ADDR_W'(shadow_start[i] + META_BYTES);
            done = 1'b1;
          end
        end
        // carve at the top; heap check comes before table check
        if (!done) begin
          new_top = top_of_heap + META_BYTES + want;
          if (new_top >= HEAP_BYTES) begin
            r.status = ST_EXHAUSTED;
          end else if (blocks_used >= MAX_BLOCKS) begin
            r.status = ST_TABLE_FULL;
          end else begin
            shadow_start[blocks_used] = TOP_W'(top_of_heap);
            shadow_len[blocks_used]   = want;
            shadow_avail[blocks_used] = 1'b0;
            r.grant = ADDR_W'(top_of_heap + META_BYTES);
            blocks_used++;
            top_of_heap = new_top;
          end
        end
      end
    end else if (addr != '0) begin
      for (int i = 0; i < blocks_used && !done; i++) begin
        if (ADDR_W'(shadow_start[i] + META_BYTES) == addr) begin
          shadow_avail[i] = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) r.status = ST_UNKNOWN;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_reply_t       due;
    logic [ADDR_W-1:0] got_grant;
    logic [2:0]        got_status;
    if (!rst_ni) begin
      blocks_used = 0;
      top_of_heap = 0;
      replies_due.delete();
    end else begin
      // request word accepted
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        replies_due.push_back(predict_reply(action_e'(s_axis_tuser_i),
                                            s_axis_tdata_i[SIZE_W-1:0],
                                            s_axis_tdata_i[SIZE_W +: ADDR_W]));
      end
      // reply word accepted
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_grant  = m_axis_tdata_i[ADDR_W-1:0];
        got_status = m_axis_tdata_i[ADDR_W +: STATUS_W];
        if (replies_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: reply word %0d with nothing outstanding: grant %h status %0d",
                     $time, words_seen, got_grant, got_status);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (due.grant != got_grant || due.status != got_status) begin
            if (mismatches < 10)
              $display("%0t: reply word %0d grant exp %h got %h, status exp %0d got %0d",
                       $time, words_seen, due.grant, got_grant, due.status, got_status);
            mismatches++;
          end
        end
        words_seen++;
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= replies_due.size();
  end

endmodule

// ----- bench/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 680;
  localparam int unsigned QUIET_TAIL   = 120;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_valid  = 1'b0;
  logic             s_ready;
  logic [IN_W-1:0]  s_data   = '0;
  logic             s_user   = 1'b0;
  logic             m_valid;
  logic             m_ready  = 1'b0;
  logic [OUT_W-1:0] m_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          idle_on     = 1'b1;

  // payload addresses seen granted, used to pick free targets
  logic [ADDR_W-1:0] granted_pool[$];

  first_fit_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  first_fit_block_allocator_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_block_allocator_tb failed");
      $finish;
    end
  end

  // Downstream back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Collect granted addresses from accepted reply words
  always @(posedge clk_i) begin
    if (m_valid && m_ready && m_data[ADDR_W +: STATUS_W] == ST_OK &&
        m_data[ADDR_W-1:0] != '0) begin
      if (granted_pool.size() >= 128) granted_pool.delete(0);
      granted_pool.push_back(m_data[ADDR_W-1:0]);
    end
  end

  // Present one request word and hold it until accepted
  task automatic send_word(input action_e act, input logic [SIZE_W-1:0] bytes_req,
                           input logic [ADDR_W-1:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {addr, bytes_req};
    do @(posedge clk_i); while (!s_ready);
  endtask

  initial begin
    int unsigned       pick;
    logic [11:0]       junk;
    logic [ADDR_W-1:0] target;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: refusals, reuse, double free, exact heap boundary
    send_word(ACT_ALLOC, 12'd0,    12'd0);     // zero size
    send_word(ACT_FREE,  12'd0,    12'd0);     // null free
    send_word(ACT_ALLOC, 12'hFFF,  12'd0);     // far past heap end
    send_word(ACT_FREE,  12'd0,    12'hFFF);   // unknown, empty table
    send_word(ACT_ALLOC, 12'd1,    12'd0);     // carve at 0
    send_word(ACT_ALLOC, 12'd16,   12'd0);     // carve at 5
    send_word(ACT_FREE,  12'd0,    12'd4);
    send_word(ACT_FREE,  12'd0,    12'd4);     // double free
    send_word(ACT_ALLOC, 12'd2,    12'd0);     // free block too short, carve
    send_word(ACT_ALLOC, 12'd1,    12'd0);     // reuse first block
    send_word(ACT_FREE,  12'd0,    12'd9);
    send_word(ACT_FREE,  12'd0,    12'd29);
    send_word(ACT_ALLOC, 12'd10,   12'd0);     // first fit skips nothing, no split
    send_word(ACT_ALLOC, 12'd2,    12'd0);
    send_word(ACT_FREE,  12'd0,    12'd5);     // off by one, unknown
    send_word(ACT_ALLOC, 12'd4061, 12'd0);     // new top lands exactly on heap end
    send_word(ACT_ALLOC, 12'h800,  12'd0);
    send_word(ACT_FREE,  12'd0,    12'h800);
    send_word(ACT_ALLOC, 12'd16,   12'd0);
    send_word(ACT_FREE,  12'd0,    12'd35);
    send_word(ACT_ALLOC, 12'd16,   12'd0);     // reuse of a longer free block, no split

    // Random: mostly small allocations so the table fills before the heap
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_on = !((i >= 300 && i < 360) || i >= RANDOM_WORDS - QUIET_TAIL);
      pick = $urandom_range(0, 99);
      junk = 12'($urandom);
      if (pick < 55) begin
        send_word(ACT_ALLOC, 12'($urandom_range(1, 48)), junk);
      end else if (pick < 60) begin
        // big requests only once the table had time to fill
        if (i >= 300) send_word(ACT_ALLOC, 12'($urandom), junk);
        else send_word(ACT_ALLOC, 12'($urandom_range(1, 64)), junk);
      end else if (pick < 62) begin
        send_word(ACT_ALLOC, 12'd0, junk);
      end else if (pick < 92 && granted_pool.size() != 0) begin
        target = granted_pool[$urandom_range(0, granted_pool.size() - 1)];
        send_word(ACT_FREE, junk, target);
      end else if (pick < 97) begin
        send_word(ACT_FREE, junk, 12'($urandom));
      end else begin
        send_word(ACT_FREE, junk, 12'd0);
      end
    end
    s_valid <= 1'b0;

    // Drain outstanding replies, then let the block settle
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("first_fit_block_allocator_tb passed");
    end else begin
      $display("first_fit_block_allocator_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
bench/first_fit_block_allocator_checker.sv
bench/first_fit_block_allocator_tb.sv
